// File: sv/murmur64a_key_hash_bucket_assert.svh
// Assertion macros for the MurmurHash64A key hasher.
// Depends on nothing; the SYNTH macro selects empty bodies for synthesis.
`ifndef MURMUR64A_KEY_HASH_BUCKET_ASSERT_SVH
`define MURMUR64A_KEY_HASH_BUCKET_ASSERT_SVH

`ifndef SYNTH
`define MKHB_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mkhb assertion failed");
`define MKHB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mkhb assertion failed");
`else
`define MKHB_ASSERT_IMP(name, clk, rst_n, pre, post)
`define MKHB_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

// File: sv/mkhb_pkg.sv
// Shared types, constants and helpers of the MurmurHash64A key hasher.
// Used by the controller, the datapath and the top level.
package mkhb_pkg;

    localparam logic [63:0] MUL_K    = 64'hc6a4a7935bd1e995;
    localparam int unsigned SHIFT_R  = 47;
    localparam int unsigned BUCKET_W = 10;

    typedef struct packed {
        logic [7:0]  key_byte;
        logic [15:0] key_length;
        logic        first_of_key;
        logic        last_of_key;
        logic        empty_key;
    } key_in_t;

    typedef struct packed {
        logic [63:0]         hash_value;
        logic [BUCKET_W-1:0] bucket_index;
        logic                length_error;
    } hash_out_t;

    typedef enum logic [2:0] {
        MOP_KLEN,
        MOP_WORD,
        MOP_KMIX,
        MOP_ACC_K,
        MOP_TAIL,
        MOP_FIN
    } mop_sel_t;

    typedef enum logic [1:0] {
        MP_LO_LO,
        MP_LO_HI,
        MP_HI_LO
    } mul_phase_t;

    typedef struct packed {
        logic       item_load;
        logic       seed_acc;
        logic       seed_wr;
        logic       absorb;
        logic       prod_to_acc;
        logic       mul_load;
        mop_sel_t   mul_sel;
        logic       mul_step;
        mul_phase_t mul_phase;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_empty;
        logic item_first;
        logic item_last;
        logic word_full;
        logic tail_pending;
        logic out_free;
    } dp_status_t;

    function automatic logic [63:0] xorshift47(input logic [63:0] h);
        return h ^ (h >> SHIFT_R);
    endfunction

endpackage

// File: sv/mkhb_ctrl.sv
// Sequencing state machine of the MurmurHash64A key hasher.
// Depends on mkhb_pkg; drives the datapath through ctrl_cmd_t.
module mkhb_ctrl
    import mkhb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEED_WR,
        S_ABSORB,
        S_W1_LD,
        S_W2_LD,
        S_W3_LD,
        S_WORD_WR,
        S_CHECK,
        S_TAIL_LD,
        S_TAIL_WR,
        S_FIN_LD,
        S_MUL,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    mul_phase_t phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        phase_next = phase_reg;
        cmd        = '0;
        key_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                key_ready = 1'b1;
                if (key_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.item_empty)
                begin
                    cmd.seed_acc = 1'b1;
                    state_next   = S_FIN_LD;
                end
                else if (status.item_first)
                begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MOP_KLEN;
                    ret_next     = S_SEED_WR;
                    phase_next   = MP_LO_LO;
                    state_next   = S_MUL;
                end
                else
                begin
                    state_next = S_ABSORB;
                end
            end
            S_SEED_WR:
            begin
                cmd.seed_wr = 1'b1;
                state_next  = S_ABSORB;
            end
            S_ABSORB:
            begin
                cmd.absorb = 1'b1;
                state_next = status.word_full ? S_W1_LD : S_CHECK;
            end
            S_W1_LD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MOP_WORD;
                ret_next     = S_W2_LD;
                phase_next   = MP_LO_LO;
                state_next   = S_MUL;
            end
            S_W2_LD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MOP_KMIX;
                ret_next     = S_W3_LD;
                phase_next   = MP_LO_LO;
                state_next   = S_MUL;
            end
            S_W3_LD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MOP_ACC_K;
                ret_next     = S_WORD_WR;
                phase_next   = MP_LO_LO;
                state_next   = S_MUL;
            end
            S_WORD_WR:
            begin
                cmd.prod_to_acc = 1'b1;
                state_next      = S_CHECK;
            end
            S_CHECK:
            begin
                if (!status.item_last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.tail_pending)
                begin
                    state_next = S_TAIL_LD;
                end
                else
                begin
                    state_next = S_FIN_LD;
                end
            end
            S_TAIL_LD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MOP_TAIL;
                ret_next     = S_TAIL_WR;
                phase_next   = MP_LO_LO;
                state_next   = S_MUL;
            end
            S_TAIL_WR:
            begin
                cmd.prod_to_acc = 1'b1;
                state_next      = S_FIN_LD;
            end
            S_FIN_LD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MOP_FIN;
                ret_next     = S_EMIT;
                phase_next   = MP_LO_LO;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step  = 1'b1;
                cmd.mul_phase = phase_reg;
                case (phase_reg)
                    MP_LO_LO: phase_next = MP_LO_HI;
                    MP_LO_HI: phase_next = MP_HI_LO;
                    MP_HI_LO: state_next = ret_reg;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            phase_reg <= MP_LO_LO;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// File: sv/mkhb_datapath.sv
// Datapath of the MurmurHash64A key hasher: stream state, shared 32x32
// multiplier, seed register and result register. Depends on mkhb_pkg.
module mkhb_datapath
    import mkhb_pkg::*;
#(
    parameter int BUCKET_BITS = 10,
    parameter int LENGTH_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_in_t     key_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    output logic        hash_valid,
    input  logic        hash_ready,
    output hash_out_t   hash_data,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status
);

    logic [63:0]            seed_reg;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            wbuf_reg, wbuf_next;
    logic [2:0]             idx_reg, idx_next;
    logic [LENGTH_BITS-1:0] seen_reg, seen_next;
    logic [LENGTH_BITS-1:0] decl_reg, decl_next;
    key_in_t                item_reg;
    logic [63:0]            opnd_reg;
    logic [63:0]            prod_reg, prod_next;
    logic                   valid_reg, valid_next;
    hash_out_t              out_reg;

    logic [LENGTH_BITS-1:0] klen;
    logic [63:0]            opnd_sel;
    logic [31:0]            mul_x, mul_y;
    logic [63:0]            pp;
    logic [63:0]            fin;
    logic [BUCKET_W-1:0]    bucket;
    logic                   err;

    assign cfg_ready  = 1'b1;
    assign hash_valid = valid_reg;
    assign hash_data  = out_reg;

    assign klen = LENGTH_BITS'(item_reg.key_length);
    assign fin  = xorshift47(prod_reg);
    assign err  = item_reg.empty_key ? (klen != '0) : (seen_reg != decl_reg);

    assign status.item_empty   = item_reg.empty_key;
    assign status.item_first   = item_reg.first_of_key;
    assign status.item_last    = item_reg.last_of_key;
    assign status.word_full    = (idx_reg == 3'd7);
    assign status.tail_pending = (idx_reg != 3'd0);
    assign status.out_free     = !valid_reg || hash_ready;

    always_comb
    begin
        for (int i = 0; i < BUCKET_W; i++)
        begin
            bucket[i] = (i < BUCKET_BITS) ? fin[i] : 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MOP_KLEN:  opnd_sel = 64'(klen);
            MOP_WORD:  opnd_sel = wbuf_reg;
            MOP_KMIX:  opnd_sel = xorshift47(prod_reg);
            MOP_ACC_K: opnd_sel = acc_reg ^ prod_reg;
            MOP_TAIL:  opnd_sel = acc_reg ^ wbuf_reg;
            MOP_FIN:   opnd_sel = xorshift47(acc_reg);
            default:   opnd_sel = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.mul_phase)
            MP_LO_LO:
            begin
                mul_x = opnd_reg[31:0];
                mul_y = MUL_K[31:0];
            end
            MP_LO_HI:
            begin
                mul_x = opnd_reg[31:0];
                mul_y = MUL_K[63:32];
            end
            MP_HI_LO:
            begin
                mul_x = opnd_reg[63:32];
                mul_y = MUL_K[31:0];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        pp = 64'(mul_x) * 64'(mul_y);
        if (cmd.mul_phase == MP_LO_LO)
        begin
            prod_next = pp;
        end
        else
        begin
            prod_next = prod_reg + {pp[31:0], 32'd0};
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        wbuf_next = wbuf_reg;
        idx_next  = idx_reg;
        seen_next = seen_reg;
        decl_next = decl_reg;
        if (cmd.seed_acc)
        begin
            acc_next = seed_reg;
        end
        if (cmd.seed_wr)
        begin
            acc_next  = seed_reg ^ prod_reg;
            wbuf_next = '0;
            idx_next  = '0;
            seen_next = '0;
            decl_next = klen;
        end
        if (cmd.absorb)
        begin
            wbuf_next[{idx_reg, 3'b000} +: 8] = wbuf_reg[{idx_reg, 3'b000} +: 8]
                                              | item_reg.key_byte;
            idx_next  = idx_reg + 3'd1;
            seen_next = seen_reg + LENGTH_BITS'(1);
        end
        if (cmd.prod_to_acc)
        begin
            acc_next  = prod_reg;
            wbuf_next = '0;
        end
        if (cmd.out_load)
        begin
            acc_next  = '0;
            wbuf_next = '0;
            idx_next  = '0;
            seen_next = '0;
            decl_next = '0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (hash_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            acc_reg   <= '0;
            wbuf_reg  <= '0;
            idx_reg   <= '0;
            seen_reg  <= '0;
            decl_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= cfg_data;
            end
            acc_reg   <= acc_next;
            wbuf_reg  <= wbuf_next;
            idx_reg   <= idx_next;
            seen_reg  <= seen_next;
            decl_reg  <= decl_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= key_data;
        end
        if (cmd.mul_load)
        begin
            opnd_reg <= opnd_sel;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            out_reg.hash_value   <= fin;
            out_reg.bucket_index <= bucket;
            out_reg.length_error <= err;
        end
    end

endmodule

// File: sv/murmur64a_key_hash_bucket.sv
// A byte that completes an 8-byte word needs three 64-bit multiplies on the
// shared 32x32 multiplier. A first byte adds a multiply for seeding; a last byte
// adds one for a pending tail and the finalize multiply, then the result is
// registered once the output is free. An empty key only finalizes the seed.
// One key transaction is in work at a time; the result register frees the input side.
// Reset clears the seed to zero and the stream state; no clearing pass is needed.
`include "murmur64a_key_hash_bucket_assert.svh"

module murmur64a_key_hash_bucket
    import mkhb_pkg::*;
#(
    parameter int BUCKET_BITS = 10,
    parameter int LENGTH_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_ready,
    input  key_in_t     key_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    output logic        hash_valid,
    input  logic        hash_ready,
    output hash_out_t   hash_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mkhb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mkhb_datapath #(
        .BUCKET_BITS (BUCKET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_data   (key_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_data  (hash_data),
        .cmd        (cmd),
        .status     (status)
    );

    `MKHB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, key_valid && key_ready, !key_ready)
    `MKHB_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !hash_valid || hash_ready)
    `MKHB_ASSERT_NEXT(a_stream_cleared, clk, rst_n, cmd.out_load, !status.tail_pending)

endmodule

// File: tb/murmur64a_key_hash_bucket_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for murmur64a_key_hash_bucket: streams keys byte by byte
// and compares each hash result against an in-bench MurmurHash64A predictor or a fixed row.
// Depends on mkhb_pkg and the murmur64a_key_hash_bucket RTL only.
module murmur64a_key_hash_bucket_tb;
    import mkhb_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 48;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned LONG_KEY_BYTES = 200;
    localparam int unsigned ITEM_W = $bits(key_in_t);

    typedef struct packed {
        key_in_t   item;
        logic      fixed;
        hash_out_t want;
    } dir_row_t;

    // Byte, length, first, last, empty, fixed, hash, bucket, error.
    localparam dir_row_t DIR_ROWS [22] = '{
        {8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1, 64'h0, 10'h000, 1'b1},
        {8'h5a, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0, 10'h000, 1'b0},
        {8'hff, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1, 64'h0, 10'h000, 1'b1},
        {8'hff, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h00, 16'h0008, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'hff, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h01, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h80, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h7f, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'hfe, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h55, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'haa, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'hff, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'hff, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'hff, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h12, 16'h0005, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h13, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0, 10'h000, 1'b0},
        {8'h34, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h56, 16'h0002, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0},
        {8'h78, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 64'h0, 10'h000, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        key_valid;
    logic        key_ready;
    key_in_t     key_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;
    logic        hash_valid;
    logic        hash_ready;
    hash_out_t   hash_data;

    logic [63:0] seed_reg;
    logic [63:0] acc_st;
    logic [63:0] word_st;
    logic [2:0]  lane_st;
    logic [15:0] seen_st;
    logic [15:0] decl_st;

    hash_out_t   hash_expect_q [$];
    int unsigned items_sent;
    int unsigned fail_count;
    bit          idle_en;
    bit          long_hold_req;
    bit          long_hold_done;
    int unsigned long_left;
    int unsigned stall_left;

    murmur64a_key_hash_bucket u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .key_data   (key_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_data  (hash_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("murmur64a_key_hash_bucket_tb: FAIL");
        $finish;
    end

    function automatic logic [63:0] avalanche(input logic [63:0] h);
        logic [63:0] x;
        x = h ^ (h >> SHIFT_R);
        x = x * MUL_K;
        return x ^ (x >> SHIFT_R);
    endfunction

    task automatic drop_key_state();
        acc_st  = '0;
        word_st = '0;
        lane_st = '0;
        seen_st = '0;
        decl_st = '0;
    endtask

    task automatic hash_key_byte(input key_in_t it, output bit done, output hash_out_t res);
        logic [63:0] k;
        logic [63:0] h;
        done = 1'b0;
        res  = '0;
        if (it.empty_key)
        begin
            h = avalanche(seed_reg);
            res = {h, h[BUCKET_W-1:0], it.key_length != 16'd0};
            done = 1'b1;
            drop_key_state();
        end
        else
        begin
            if (it.first_of_key)
            begin
                acc_st  = seed_reg ^ ({48'd0, it.key_length} * MUL_K);
                word_st = '0;
                lane_st = '0;
                seen_st = '0;
                decl_st = it.key_length;
            end
            word_st = word_st | ({56'd0, it.key_byte} << (lane_st * 8));
            seen_st = seen_st + 16'd1;
            if (lane_st == 3'd7)
            begin
                k = word_st * MUL_K;
                k = k ^ (k >> SHIFT_R);
                k = k * MUL_K;
                acc_st  = (acc_st ^ k) * MUL_K;
                word_st = '0;
                lane_st = '0;
            end
            else
            begin
                lane_st = lane_st + 3'd1;
            end
            if (it.last_of_key)
            begin
                h = acc_st;
                if (lane_st != 3'd0)
                begin
                    h = (h ^ word_st) * MUL_K;
                end
                h = avalanche(h);
                res = {h, h[BUCKET_W-1:0], seen_st != decl_st};
                done = 1'b1;
                drop_key_state();
            end
        end
    endtask

    task automatic report_bad(input string what, input logic [63:0] want, input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic offer_key(input key_in_t it, input bit use_fixed, input hash_out_t fixed_res);
        bit        done;
        hash_out_t res;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            key_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        key_valid <= 1'b1;
        key_data  <= it;
        @(posedge clk);
        while (!key_ready) @(posedge clk);
        hash_key_byte(it, done, res);
        if (done)
        begin
            hash_expect_q.push_back(use_fixed ? fixed_res : res);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        key_valid <= 1'b0;
        while (hash_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_seed(input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        seed_reg = value;
    endtask

    task automatic send_random_key();
        key_in_t     it;
        int unsigned len;
        int unsigned cut;
        int unsigned pick;
        logic [15:0] decl;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            it = ITEM_W'($urandom);
            it.empty_key = 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                it.key_length = '0;
            end
            offer_key(it, 1'b0, '0);
        end
        else if (pick < 9)
        begin
            it = ITEM_W'($urandom);
            it.first_of_key = 1'b0;
            it.empty_key = 1'b0;
            offer_key(it, 1'b0, '0);
        end
        else
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
            decl = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(len);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len + 1;
            for (int unsigned i = 0; i < len && i < cut; i++)
            begin
                it = ITEM_W'($urandom);
                it.key_length   = (i == 0) ? decl : 16'($urandom);
                it.first_of_key = (i == 0);
                it.last_of_key  = (i == len - 1);
                it.empty_key    = 1'b0;
                offer_key(it, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin : rx_pace
        logic next_ready;
        next_ready = 1'b1;
        if (long_hold_req && !long_hold_done)
        begin
            long_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        if (long_left != 0)
        begin
            long_left--;
            next_ready = 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else if (idle_en && rst_n && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            next_ready = 1'b0;
        end
        hash_ready <= next_ready;
    end

    always @(posedge clk)
    begin : hash_check
        hash_out_t want;
        if (rst_n && hash_valid && hash_ready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                report_bad("unexpected transaction", '0, hash_data.hash_value);
            end
            else
            begin
                want = hash_expect_q.pop_front();
                if (hash_data.hash_value !== want.hash_value)
                begin
                    report_bad("hash_value", want.hash_value, hash_data.hash_value);
                end
                if (hash_data.bucket_index !== want.bucket_index)
                begin
                    report_bad("bucket_index", 64'(want.bucket_index),
                               64'(hash_data.bucket_index));
                end
                if (hash_data.length_error !== want.length_error)
                begin
                    report_bad("length_error", 64'(want.length_error),
                               64'(hash_data.length_error));
                end
            end
        end
    end

    initial
    begin
        key_in_t it;
        rst_n          = 1'b0;
        key_valid      = 1'b0;
        key_data       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        seed_reg       = '0;
        items_sent     = 0;
        fail_count     = 0;
        idle_en        = 1'b1;
        long_hold_req  = 1'b0;
        drop_key_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_seed(64'd0);
        foreach (DIR_ROWS[i])
        begin
            offer_key(DIR_ROWS[i].item, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
        end

        drain_results();
        load_seed(64'hffff_ffff_ffff_ffff);
        long_hold_req = 1'b1;
        while (items_sent < 600) send_random_key();

        drain_results();
        load_seed({$urandom, $urandom});
        while (items_sent < 1100) send_random_key();
        idle_en = 1'b0;
        for (int unsigned i = 0; i < LONG_KEY_BYTES; i++)
        begin
            it = ITEM_W'($urandom);
            it.key_length   = (i == 0) ? 16'd1 : 16'($urandom);
            it.first_of_key = (i == 0);
            it.last_of_key  = (i == LONG_KEY_BYTES - 1);
            it.empty_key    = 1'b0;
            offer_key(it, 1'b0, '0);
        end
        idle_en = 1'b1;
        while (items_sent < 1400) send_random_key();

        drain_results();
        load_seed({$urandom, $urandom});
        idle_en = 1'b0;
        while (items_sent < 1800) send_random_key();

        drain_results();
        if (hash_expect_q.size() != 0)
        begin
            report_bad("missing transactions", 64'(hash_expect_q.size()), 64'd0);
        end
        if (fail_count == 0)
        begin
            $display("murmur64a_key_hash_bucket_tb: PASS");
        end
        else
        begin
            $display("murmur64a_key_hash_bucket_tb: FAIL");
        end
        $finish;
    end

endmodule
